### design/itdt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itdt_pkg: shared types and constants for the decimal text core
// Character codes and the converter state encoding.
// ----------------------------------------------------------------------------
package itdt_pkg;

   localparam logic [7:0] CHAR_ZERO  = 8'd48;
   localparam logic [7:0] CHAR_MINUS = 8'd45;
   localparam logic [3:0] BCD_FIVE   = 4'd5;
   localparam logic [3:0] BCD_ADJUST = 4'd3;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_CONVERT,
      BK_LOCATE,
      BK_SIGN,
      BK_DIGITS
   } back_state_type;

endpackage

### design/itdt_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itdt_front: input stage
// Takes a signed value, splits it into sign and unsigned magnitude, holds it.
// ----------------------------------------------------------------------------
module itdt_front #(
   parameter int VALUE_BITS = 32
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic signed [VALUE_BITS-1:0] req_value,
   output logic                         item_valid,
   input  logic                         item_ready,
   output logic [VALUE_BITS:0]          item_data
);
   import itdt_pkg::*;

   logic                  valid_ff, valid_in;
   logic                  neg_ff, neg_in;
   logic [VALUE_BITS-1:0] mag_ff, mag_in;
   logic [VALUE_BITS-1:0] raw;
   logic                  take;

   assign raw       = VALUE_BITS'(req_value);
   assign req_ready = !valid_ff || item_ready;
   assign take      = req_valid && req_ready;

   always_comb begin
      neg_in   = raw[VALUE_BITS-1];
      mag_in   = neg_in ? VALUE_BITS'(~raw + 1'b1) : raw;
      valid_in = take || (valid_ff && !item_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         neg_ff <= neg_in;
         mag_ff <= mag_in;
      end
   end

   assign item_valid = valid_ff;
   assign item_data  = {neg_ff, mag_ff};

endmodule

### design/itdt_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itdt_queue: two-entry queue
// Decouples the input stage from the converter.
// ----------------------------------------------------------------------------
module itdt_queue #(
   parameter int WIDTH = 33
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output logic [WIDTH-1:0] pop_data
);
   import itdt_pkg::*;

   logic [WIDTH-1:0] mem_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;
   logic             push, pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_data   = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### design/itdt_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itdt_back: converter and character emitter
// Shift-add-3 binary to BCD, one bit per cycle, then emits the text.
// ----------------------------------------------------------------------------
module itdt_back #(
   parameter int VALUE_BITS = 32,
   parameter int MAX_DIGITS = 10
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                item_valid,
   output logic                item_ready,
   input  logic [VALUE_BITS:0] item_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [7:0]          rsp_text_char,
   output logic                rsp_last_char
);
   import itdt_pkg::*;

   localparam int BCD_DIGITS  = (VALUE_BITS * 1233) / 4096 + 1;
   localparam int BCD_W       = BCD_DIGITS * 4;
   localparam int EMIT_DIGITS = (BCD_DIGITS < MAX_DIGITS) ? BCD_DIGITS : MAX_DIGITS;
   localparam int POS_W       = $clog2(EMIT_DIGITS);
   localparam int STEP_W      = $clog2(VALUE_BITS);

   back_state_type        state_ff, state_in;
   logic [VALUE_BITS-1:0] mag_ff, mag_in;
   logic [BCD_W-1:0]      bcd_ff, bcd_in;
   logic                  neg_ff, neg_in;
   logic [STEP_W-1:0]     step_ff, step_in;
   logic [POS_W-1:0]      pos_ff, pos_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [7:0]            rsp_char_ff, rsp_char_in;
   logic                  rsp_last_ff, rsp_last_in;
   logic [BCD_W-1:0]      adj;
   logic [POS_W-1:0]      top;
   logic [3:0]            digit;
   logic                  out_free;
   logic                  load;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign digit    = bcd_ff[pos_ff*4 +: 4];

   always_comb begin
      for (int i = 0; i < BCD_DIGITS; i++) begin
         adj[i*4 +: 4] = (bcd_ff[i*4 +: 4] >= BCD_FIVE) ?
                         bcd_ff[i*4 +: 4] + BCD_ADJUST : bcd_ff[i*4 +: 4];
      end
   end

   always_comb begin
      top = '0;
      for (int i = 0; i < BCD_DIGITS; i++) begin
         if (bcd_ff[i*4 +: 4] != 4'd0) begin
            top = (i >= EMIT_DIGITS) ? POS_W'(EMIT_DIGITS - 1) : POS_W'(i);
         end
      end
   end

   always_comb begin
      state_in    = state_ff;
      mag_in      = mag_ff;
      bcd_in      = bcd_ff;
      neg_in      = neg_ff;
      step_in     = step_ff;
      pos_in      = pos_ff;
      item_ready  = 1'b0;
      load        = 1'b0;
      rsp_char_in = rsp_char_ff;
      rsp_last_in = rsp_last_ff;
      unique case (state_ff)
         BK_IDLE: begin
            item_ready = 1'b1;
            if (item_valid) begin
               neg_in   = item_data[VALUE_BITS];
               mag_in   = item_data[VALUE_BITS-1:0];
               bcd_in   = '0;
               step_in  = '0;
               state_in = BK_CONVERT;
            end
         end
         BK_CONVERT: begin
            bcd_in  = {adj[BCD_W-2:0], mag_ff[VALUE_BITS-1]};
            mag_in  = {mag_ff[VALUE_BITS-2:0], 1'b0};
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_W'(VALUE_BITS - 1)) begin
               state_in = BK_LOCATE;
            end
         end
         BK_LOCATE: begin
            pos_in   = top;
            state_in = neg_ff ? BK_SIGN : BK_DIGITS;
         end
         BK_SIGN: begin
            if (out_free) begin
               load        = 1'b1;
               rsp_char_in = CHAR_MINUS;
               rsp_last_in = 1'b0;
               state_in    = BK_DIGITS;
            end
         end
         BK_DIGITS: begin
            if (out_free) begin
               load        = 1'b1;
               rsp_char_in = CHAR_ZERO + {4'd0, digit};
               rsp_last_in = (pos_ff == '0);
               if (pos_ff == '0) begin
                  state_in = BK_IDLE;
               end else begin
                  pos_in = pos_ff - 1'b1;
               end
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
      rsp_valid_in = load || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff      <= mag_in;
      bcd_ff      <= bcd_in;
      neg_ff      <= neg_in;
      step_ff     <= step_in;
      pos_ff      <= pos_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_text_char = rsp_char_ff;
   assign rsp_last_char = rsp_last_ff;

`ifndef SYNTHESIS
   a_sign_only_negative: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BK_SIGN) |-> neg_ff)
      else $error("sign state entered for non-negative value");

   a_last_ends_run: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BK_DIGITS && out_free && pos_ff == '0)
         |=> (state_ff == BK_IDLE && rsp_valid_ff && rsp_last_ff))
      else $error("final digit did not end the run");

   a_char_legal: assert property (@(posedge clock) disable iff (reset)
      (load && state_ff == BK_DIGITS) |-> (digit <= 4'd9))
      else $error("non-decimal BCD digit emitted");

   a_idle_output_last: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BK_CONVERT && rsp_valid_ff) |-> rsp_last_ff)
      else $error("pending character during conversion is not the last one");
`endif

endmodule

### design/integer_to_decimal_text_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_to_decimal_text_core: signed integer to decimal ASCII text
// Converts one signed value into a run of characters, most significant first.
// ----------------------------------------------------------------------------
// Usage:
//   req_* channel: one signed VALUE_BITS integer per transfer (req_valid/ready).
//   rsp_* channel: one ASCII character per transfer; '-' first for negative
//   values, then digits without leading zeros; rsp_last_char marks the final
//   character of each number. Zero gives a single '0'.
//   The input stage registers sign and magnitude and feeds a two-entry queue.
//   The converter runs one shift-add-3 step per cycle for each of the VALUE_BITS
//   bits, then locates the leading digit, then emits one character a cycle
//   while rsp_ready allows. The converter takes a new value only after it has
//   loaded the final character of the previous one.
//   Stalls on rsp_ready hold the current character; the input stage and queue
//   keep accepting up to three values while the converter waits.
//   Synchronous reset empties the queue and output register; no clearing pass.
// ----------------------------------------------------------------------------
module integer_to_decimal_text_core #(
   parameter int VALUE_BITS = 32,
   parameter int MAX_DIGITS = 10
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic signed [VALUE_BITS-1:0] req_value,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [7:0]                   rsp_text_char,
   output logic                         rsp_last_char
);
   import itdt_pkg::*;

   logic                f_valid, f_ready;
   logic [VALUE_BITS:0] f_data;
   logic                q_valid, q_ready;
   logic [VALUE_BITS:0] q_data;

   itdt_front #(
      .VALUE_BITS(VALUE_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_value (req_value),
      .item_valid(f_valid),
      .item_ready(f_ready),
      .item_data (f_data)
   );

   itdt_queue #(
      .WIDTH(VALUE_BITS + 1)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push_valid(f_valid),
      .push_ready(f_ready),
      .push_data (f_data),
      .pop_valid (q_valid),
      .pop_ready (q_ready),
      .pop_data  (q_data)
   );

   itdt_back #(
      .VALUE_BITS(VALUE_BITS),
      .MAX_DIGITS(MAX_DIGITS)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .item_valid   (q_valid),
      .item_ready   (q_ready),
      .item_data    (q_data),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_text_char(rsp_text_char),
      .rsp_last_char(rsp_last_char)
   );

endmodule

### tb/sv/itdt_text_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itdt_text_checker: character stream checker for the decimal text core
// Watches both channels, predicts the decimal text of each accepted value
// and compares every character transfer against the oldest prediction.
// ----------------------------------------------------------------------------
module itdt_text_checker #(
   parameter int VALUE_BITS = 32,
   parameter int MAX_DIGITS = 10
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic                         req_ready,
   input  logic signed [VALUE_BITS-1:0] req_value,
   input  logic                         rsp_valid,
   input  logic                         rsp_ready,
   input  logic [7:0]                   rsp_text_char,
   input  logic                         rsp_last_char,
   output int                           mismatch_count,
   output int                           chars_pending
);
   import itdt_pkg::*;

   localparam int RADIX = 10;

   typedef struct packed {
      logic [7:0] text_char;
      logic       last_char;
   } text_item_type;

   text_item_type expected_text[$];
   int            errors = 0;

   task automatic push_decimal_text(input logic [VALUE_BITS-1:0] raw);
      logic [VALUE_BITS-1:0] magnitude;
      logic [3:0]            digits[MAX_DIGITS];
      int                    count;
      text_item_type         item;
      magnitude = raw[VALUE_BITS-1] ? (~raw + 1'b1) : raw;
      count = 0;
      do begin
         digits[count] = 4'(magnitude % RADIX);
         magnitude     = magnitude / RADIX;
         count++;
      end while (magnitude != 0 && count < MAX_DIGITS);
      if (raw[VALUE_BITS-1]) begin
         item.text_char = CHAR_MINUS;
         item.last_char = 1'b0;
         expected_text.push_back(item);
      end
      for (int i = count - 1; i >= 0; i--) begin
         item.text_char = CHAR_ZERO + 8'(digits[i]);
         item.last_char = (i == 0);
         expected_text.push_back(item);
      end
   endtask

   always @(posedge clock) begin
      text_item_type want;
      if (reset) begin
         expected_text.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_text.size() == 0) begin
               errors++;
               $display("%0t: unexpected character transfer: got char %0d last %0b",
                        $time, rsp_text_char, rsp_last_char);
            end else begin
               want = expected_text.pop_front();
               if (rsp_text_char !== want.text_char) begin
                  errors++;
                  $display("%0t: text_char mismatch: expected %0d, actual %0d",
                           $time, want.text_char, rsp_text_char);
               end
               if (rsp_last_char !== want.last_char) begin
                  errors++;
                  $display("%0t: last_char mismatch: expected %0b, actual %0b",
                           $time, want.last_char, rsp_last_char);
               end
            end
         end
         if (req_valid && req_ready)
            push_decimal_text(req_value);
      end
      mismatch_count <= errors;
      chars_pending  <= expected_text.size();
   end

endmodule

### tb/sv/tb_integer_to_decimal_text_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_integer_to_decimal_text_core: testbench for the decimal text core
// Drives directed and random signed values through phases of sender and
// receiver idling plus a long receiver hold-off; the checker beside the core
// predicts each character and the top reports the verdict.
// ----------------------------------------------------------------------------
module tb_integer_to_decimal_text_core;

   localparam int VALUE_BITS  = 32;
   localparam int MAX_DIGITS  = 10;
   localparam int CYCLE_LIMIT = 400000;
   localparam int HOLD_CYCLES = 400;
   localparam int DRAIN_WAIT  = 60;

   logic                         clock;
   logic                         reset;
   logic                         req_valid;
   logic                         req_ready;
   logic signed [VALUE_BITS-1:0] req_value;
   logic                         rsp_valid;
   logic                         rsp_ready;
   logic [7:0]                   rsp_text_char;
   logic                         rsp_last_char;
   int                           mismatch_count;
   int                           chars_pending;

   int sender_idle_pct = 0;
   int receiver_stall_pct = 0;
   bit hold_off_request = 0;
   int cycle_count = 0;

   integer_to_decimal_text_core #(
      .VALUE_BITS(VALUE_BITS),
      .MAX_DIGITS(MAX_DIGITS)
   ) u_top (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_value    (req_value),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_text_char(rsp_text_char),
      .rsp_last_char(rsp_last_char)
   );

   itdt_text_checker #(
      .VALUE_BITS(VALUE_BITS),
      .MAX_DIGITS(MAX_DIGITS)
   ) u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_value     (req_value),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_text_char (rsp_text_char),
      .rsp_last_char (rsp_last_char),
      .mismatch_count(mismatch_count),
      .chars_pending (chars_pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_value <= '0;
      rsp_ready <= 1'b0;
   end

   // receiver: random stalls, long hold-off on request
   initial begin
      forever begin
         @(posedge clock);
         if (hold_off_request) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_off_request = 0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= receiver_stall_pct);
         end
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("tb_integer_to_decimal_text_core: FAIL");
      $finish;
   end

   task automatic send_value(input logic signed [VALUE_BITS-1:0] value);
      while (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_value <= value;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic wait_text_drained();
      do @(posedge clock); while (chars_pending != 0);
   endtask

   function automatic logic signed [VALUE_BITS-1:0] random_value();
      logic [VALUE_BITS-1:0] bits;
      bits = $urandom >> $urandom_range(31, 0);
      case ($urandom_range(3))
         0:       return $urandom;
         1:       return -bits;
         default: return bits;
      endcase
   endfunction

   task automatic send_random(input int count);
      repeat (count) send_value(random_value());
   endtask

   initial begin
      logic signed [VALUE_BITS-1:0] directed[$];
      directed = '{32'sd0, 32'sd1, -32'sd1, 32'sd9, 32'sd10, -32'sd10, 32'sd99,
                   32'sd100, 32'sd2147483647, 32'h8000_0000, -32'sd2147483647,
                   32'sd1000000000, 32'sd999999999, -32'sd999999999,
                   32'sd1234567890, 32'sd7, -32'sd5, 32'h5555_5555,
                   32'hAAAA_AAAA, 32'h0000_FFFF, 32'hFFFF_0000};
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      foreach (directed[i]) send_value(directed[i]);
      send_random(15);
      req_valid <= 1'b0;
      wait_text_drained();

      sender_idle_pct = 86;
      send_random(20);
      req_valid <= 1'b0;
      wait_text_drained();

      sender_idle_pct    = 0;
      receiver_stall_pct = 86;
      send_random(20);
      req_valid <= 1'b0;
      wait_text_drained();

      sender_idle_pct    = 28;
      receiver_stall_pct = 28;
      send_random(20);
      req_valid <= 1'b0;
      wait_text_drained();

      // receiver holds off while values keep coming; core backs up
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      hold_off_request   = 1;
      send_random(12);
      req_valid <= 1'b0;
      wait_text_drained();

      sender_idle_pct    = 28;
      receiver_stall_pct = 28;
      send_random(10);
      req_valid <= 1'b0;
      wait_text_drained();
      repeat (DRAIN_WAIT) @(posedge clock);

      if (mismatch_count == 0 && chars_pending == 0)
         $display("tb_integer_to_decimal_text_core: PASS");
      else
         $display("tb_integer_to_decimal_text_core: FAIL");
      $finish;
   end

endmodule
